[design/stism_pkg.sv]
// ----------------------------------------------------------------------------
// stism_pkg
// Shared types and codes of the sorted key table: result status codes,
// action codes and the result record passed from sequencer to output stage.
// ----------------------------------------------------------------------------
package stism_pkg;

    localparam int POS_BITS    = 6;
    localparam int FILL_BITS   = 7;
    localparam int ACTION_BITS = 2;

    // action codes; code 3 is unused and returns ok
    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_NOT_AVAIL = 2'd3
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [POS_BITS-1:0]    position;
        logic                   table_full;
        logic [FILL_BITS-1:0]   fill_count;
    } result_t;

endpackage

[design/stism_ram.sv]
// ----------------------------------------------------------------------------
// stism_ram
// Simple dual-port table memory: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module stism_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 49
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/stism_ctrl.sv]
// ----------------------------------------------------------------------------
// stism_ctrl
// Sequencer of the sorted table. One key comparator is shared by the
// lower-bound search (insert) and the binary search (search, delete); the
// sequencer also drives the entry shift sweep through the table memory.
// ----------------------------------------------------------------------------
module stism_ctrl #(
    parameter int TABLE_DEPTH  = 64,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int AW           = $clog2(TABLE_DEPTH),
    parameter int WW           = 1 + PAYLOAD_BITS + KEY_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // item in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [stism_pkg::ACTION_BITS-1:0]  in_action,
    input  logic [KEY_BITS-1:0]                in_key,
    input  logic [PAYLOAD_BITS-1:0]            in_payload,
    input  logic                               in_available,
    // table memory
    output logic                               ram_wr_en,
    output logic [AW-1:0]                      ram_wr_addr,
    output logic [WW-1:0]                      ram_wr_data,
    output logic                               ram_rd_en,
    output logic [AW-1:0]                      ram_rd_addr,
    input  logic [WW-1:0]                      ram_rd_data,
    // result out
    output logic                               res_valid,
    input  logic                               res_ready,
    output stism_pkg::result_t                 res
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LB_RD  = 10'b00_0000_0010,
        S_LB_CMP = 10'b00_0000_0100,
        S_BS_RD  = 10'b00_0000_1000,
        S_BS_CMP = 10'b00_0001_0000,
        S_SH_RD  = 10'b00_0010_0000,
        S_SH_WR  = 10'b00_0100_0000,
        S_INS_WR = 10'b00_1000_0000,
        S_DEL_WR = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t                              state_reg, state_next;
    logic [stism_pkg::ACTION_BITS-1:0]   action_reg, action_next;
    logic [KEY_BITS-1:0]                 key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]             payload_reg, payload_next;
    logic                                avail_reg, avail_next;
    logic [AW-1:0]                       lo_reg, lo_next;
    logic [AW-1:0]                       hi_reg, hi_next;
    logic [AW-1:0]                       shift_reg, shift_next;
    logic [AW-1:0]                       pos_reg, pos_next;
    logic [CW-1:0]                       count_reg, count_next;
    stism_pkg::status_t                  status_reg, status_next;

    logic [AW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic [KEY_BITS-1:0]  rd_key;
    logic                 rd_avail;
    logic                 key_lt;
    logic                 key_eq;
    logic                 is_full;

    // shared probe arithmetic and key comparator
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[AW:1];
    assign rd_key   = ram_rd_data[KEY_BITS-1:0];
    assign rd_avail = ram_rd_data[WW-1];
    assign key_lt   = rd_key < key_reg;
    assign key_eq   = rd_key == key_reg;
    assign is_full  = count_reg == CW'(TABLE_DEPTH);

    always_comb begin
        state_next   = state_reg;
        action_next  = action_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        avail_next   = avail_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        shift_next   = shift_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = pos_reg;
        ram_wr_data  = {avail_reg, payload_reg, key_reg};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = mid;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    action_next  = in_action;
                    key_next     = in_key;
                    payload_next = in_payload;
                    avail_next   = in_available;
                    status_next  = stism_pkg::STATUS_OK;
                    pos_next     = '0;
                    lo_next      = '0;
                    state_next   = S_DONE;
                    if (in_action == stism_pkg::ACT_INSERT) begin
                        if (is_full) begin
                            status_next = stism_pkg::STATUS_FULL;
                        end else begin
                            hi_next    = AW'(count_reg);
                            state_next = S_LB_RD;
                        end
                    end else if (in_action == stism_pkg::ACT_SEARCH ||
                                 in_action == stism_pkg::ACT_DELETE) begin
                        if (count_reg == '0) begin
                            status_next = stism_pkg::STATUS_NOT_FOUND;
                        end else begin
                            hi_next    = AW'(count_reg - CW'(1));
                            state_next = S_BS_RD;
                        end
                    end
                end
            end
            S_LB_RD: begin
                if (lo_reg == hi_reg) begin
                    pos_next   = lo_reg;
                    shift_next = AW'(count_reg);
                    state_next = S_SH_RD;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_LB_CMP;
                end
            end
            S_LB_CMP: begin
                if (key_lt) begin
                    lo_next = mid + AW'(1);
                end else begin
                    hi_next = mid;
                end
                state_next = S_LB_RD;
            end
            S_BS_RD: begin
                ram_rd_en  = 1'b1;
                state_next = S_BS_CMP;
            end
            S_BS_CMP: begin
                if (key_eq) begin
                    pos_next = mid;
                    if (action_reg == stism_pkg::ACT_DELETE) begin
                        if (rd_avail) begin
                            state_next = S_DEL_WR;
                        end else begin
                            status_next = stism_pkg::STATUS_NOT_AVAIL;
                            state_next  = S_DONE;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (!key_lt) begin
                    // stored key above the wanted one: go left
                    if (mid == lo_reg) begin
                        status_next = stism_pkg::STATUS_NOT_FOUND;
                        state_next  = S_DONE;
                    end else begin
                        hi_next    = mid - AW'(1);
                        state_next = S_BS_RD;
                    end
                end else begin
                    if (mid == hi_reg) begin
                        status_next = stism_pkg::STATUS_NOT_FOUND;
                        state_next  = S_DONE;
                    end else begin
                        lo_next    = mid + AW'(1);
                        state_next = S_BS_RD;
                    end
                end
            end
            S_SH_RD: begin
                ram_rd_addr = shift_reg - AW'(1);
                if (shift_reg == pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = shift_reg;
                ram_wr_data = ram_rd_data;
                shift_next  = shift_reg - AW'(1);
                state_next  = S_SH_RD;
            end
            S_INS_WR: begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DEL_WR: begin
                // clear the mark, key and payload rewritten from the hit read
                ram_wr_en   = 1'b1;
                ram_wr_data = {1'b0, ram_rd_data[WW-2:0]};
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
        avail_reg   <= avail_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        shift_reg   <= shift_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
    end

    assign in_ready       = state_reg == S_IDLE;
    assign res_valid      = state_reg == S_DONE;
    assign res.status     = status_reg;
    assign res.position   = stism_pkg::POS_BITS'(pos_reg);
    assign res.table_full = is_full;
    assign res.fill_count = stism_pkg::FILL_BITS'(count_reg);

endmodule

[design/sorted_table_insert_search_mark.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_search_mark
// Sorted key table with insert, binary search and mark-deleted.
// ----------------------------------------------------------------------------
// One item at a time. Entries (key, payload, availability mark) sit in one
// simple dual-port memory in ascending key order, and a single comparator
// under a small sequencer does all the work. Every memory probe is a read
// followed by a compare on the registered read data. A search or delete
// does a binary search of up to floor(log2(fill))+1 probes, and a delete
// that hits an available entry then rewrites it with its mark cleared. An
// insert first finds its slot with a lower-bound search of
// ceil(log2(fill+1)) probes, then moves every later entry up one slot, one
// entry at a time (read, then write) through the single memory port pair,
// then writes the new entry. The shift sweep sets the worst case: an
// insert at slot 0 with 63 entries held. The result goes to an output
// register, so the next item can be accepted while a result is still
// waiting to be taken. The memory needs no clearing pass: the fill count
// decides which slots are live.
// ----------------------------------------------------------------------------
module sorted_table_insert_search_mark #(
    parameter int TABLE_DEPTH  = 64,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // item in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [stism_pkg::ACTION_BITS-1:0] s_action,
    input  logic [KEY_BITS-1:0]               s_entry_key,
    input  logic [PAYLOAD_BITS-1:0]           s_entry_payload,
    input  logic                              s_entry_available,
    // result out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [stism_pkg::POS_BITS-1:0]    m_position,
    output logic                              m_table_full,
    output logic [stism_pkg::FILL_BITS-1:0]   m_fill_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // memory word: {available, payload, key}
    localparam int WW = 1 + PAYLOAD_BITS + KEY_BITS;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [WW-1:0]      ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [WW-1:0]      ram_rd_data;

    logic               res_valid;
    logic               res_ready;
    stism_pkg::result_t res;

    // output register
    logic               m_valid_reg, m_valid_next;
    stism_pkg::result_t out_reg, out_next;

    stism_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stism_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .WW           (WW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_action    (s_action),
        .in_key       (s_entry_key),
        .in_payload   (s_entry_payload),
        .in_available (s_entry_available),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // the sequencer hands over its result when the output register is free
    // or is being emptied in the same cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_position   = out_reg.position;
    assign m_table_full = out_reg.table_full;
    assign m_fill_count = out_reg.fill_count;

endmodule

[design/stism_checker.sv]
// ----------------------------------------------------------------------------
// stism_checker
// Port-level checks of the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
module stism_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [1:0]                        m_status,
    input logic [stism_pkg::POS_BITS-1:0]    m_position,
    input logic                              m_table_full,
    input logic [stism_pkg::FILL_BITS-1:0]   m_fill_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_position) && $stable(m_fill_count) && $stable(m_table_full))
        else $error("stalled result changed");

    // one item at a time: no new item straight after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready straight after accept");

    // a rejected insert reports a full table at position zero
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == stism_pkg::STATUS_FULL |-> m_table_full &&
        m_position == '0)
        else $error("full rejection without full table");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == stism_pkg::STATUS_NOT_FOUND |-> m_position == '0)
        else $error("miss with non-zero position");

    // fill count stays or rises by one between consecutive results
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid ||
        m_fill_count == $past(m_fill_count) ||
        m_fill_count == $past(m_fill_count) + 1'b1)
        else $error("fill count jumped");

endmodule

bind sorted_table_insert_search_mark stism_checker u_stism_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_position        (m_position),
    .m_table_full      (m_table_full),
    .m_fill_count      (m_fill_count)
);
